/* hw/rtl/rtvl_pkg.sv */
// ----------------------------------------------------------------------------
// rtvl_pkg
// Shared widths, mode codes and controller/datapath interface types for the
// range table value lookup.
// ----------------------------------------------------------------------------
package rtvl_pkg;

	localparam int KEY_W      = 21;
	localparam int SLOT_W     = 12;
	localparam int EVAL_W     = 8;
	localparam int CNT_W      = 13;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 8;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// commands from the controller
	typedef struct packed {
		logic write;
		logic load;
		logic step;
		logic emit;
	} dp_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic load_empty;
		logic step_done;
	} dp_sts_t;

endpackage

/* hw/rtl/rtvl_ram.sv */
// ----------------------------------------------------------------------------
// rtvl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rtvl_ram #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/rtvl_ctrl.sv */
// ----------------------------------------------------------------------------
// rtvl_ctrl
// Controller for the lookup: input handshake, probe sequencing and the
// output valid flag.
// ----------------------------------------------------------------------------
module rtvl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_mode,
	output logic              m_tvalid,
	input  logic              m_tready,
	output rtvl_pkg::dp_cmd_t cmd,
	input  rtvl_pkg::dp_sts_t sts
);
	import rtvl_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PROBE  = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.write = accept && (s_mode == MODE_WRITE);
		cmd.load  = accept && (s_mode == MODE_LOOKUP);
		cmd.step  = (state_q == ST_PROBE);
		cmd.emit  = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = sts.load_empty ? ST_FINISH : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if (sts.step_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (cmd.emit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a lookup always leaves idle, a write never does
	a_lookup_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_mode == MODE_LOOKUP) |=> (state_q != ST_IDLE))
		else $error("lookup item did not start a search");

	a_write_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_mode == MODE_WRITE) |=> (state_q == ST_IDLE))
		else $error("write item left the controller busy");

	a_emit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result not presented after emit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.emit)
		else $error("pending result overwritten");

endmodule

/* hw/rtl/rtvl_dp.sv */
// ----------------------------------------------------------------------------
// rtvl_dp
// Datapath for the lookup: table memory, entry count register, search
// bounds, probe compare and the result register.
// ----------------------------------------------------------------------------
module rtvl_dp #(
	parameter int TABLE_DEPTH = 4096,
	parameter int VALUE_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rtvl_pkg::dp_cmd_t                cmd,
	output rtvl_pkg::dp_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [rtvl_pkg::CNT_W-1:0]       cfg_wdata,
	input  logic [rtvl_pkg::SLOT_W-1:0]      slot,
	input  logic [rtvl_pkg::KEY_W-1:0]       entry_key,
	input  logic [rtvl_pkg::EVAL_W-1:0]      entry_value,
	input  logic [rtvl_pkg::KEY_W-1:0]       query_key,
	output logic [rtvl_pkg::OUT_DATA_W-1:0]  found_value,
	output logic                             below_first
);
	import rtvl_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int RW = KEY_W + VALUE_BITS;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      n_eff;
	logic [CNT_W-1:0]      base_q;
	logic [CNT_W-1:0]      span_q;
	logic [CNT_W-1:0]      probe_q;
	logic [KEY_W-1:0]      query_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [OUT_DATA_W-1:0] found_q;
	logic                  below_q;

	logic [CNT_W-1:0]      half;
	logic                  key_le;
	logic [CNT_W-1:0]      step_base;
	logic [CNT_W-1:0]      step_span;
	logic [CNT_W-1:0]      next_base;
	logic [CNT_W-1:0]      next_span;
	logic [CNT_W-1:0]      next_probe;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [RW-1:0]         ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [RW-1:0]         ram_rdata;
	logic [KEY_W-1:0]      rd_key;
	logic [VALUE_BITS-1:0] rd_value;

	// writes beyond the table are dropped
	assign ram_we    = cmd.write && (32'(slot) < TABLE_DEPTH);
	assign ram_waddr = AW'(slot);
	assign ram_wdata = {VALUE_BITS'(entry_value), entry_key};

	rtvl_ram #(
		.WIDTH(RW),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_key   = ram_rdata[KEY_W-1:0];
	assign rd_value = ram_rdata[RW-1:KEY_W];

	// count saturates at the table depth
	assign n_eff = (32'(count_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : count_q;

	// one probe resolved per cycle: keep the upper part when key not above query
	assign half      = span_q >> 1;
	assign key_le    = (rd_key <= query_q);
	assign step_base = key_le ? probe_q + CNT_W'(1) : base_q;
	assign step_span = key_le ? span_q - half - CNT_W'(1) : half;

	assign next_base  = cmd.load ? '0 : step_base;
	assign next_span  = cmd.load ? n_eff : step_span;
	assign next_probe = next_base + (next_span >> 1);
	assign ram_raddr  = AW'(next_probe);

	always_comb begin
		sts            = '0;
		sts.load_empty = (n_eff == '0);
		sts.step_done  = (step_span == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
			base_q  <= '0;
			span_q  <= '0;
			probe_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.load || cmd.step) begin
				base_q  <= next_base;
				span_q  <= next_span;
				probe_q <= next_probe;
			end
			if (cmd.load) begin
				hit_q <= 1'b0;
			end else if (cmd.step && key_le) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			query_q <= query_key;
		end
		// value of the last probe that stayed at or below the query
		if (cmd.step && key_le) begin
			val_q <= rd_value;
		end
		if (cmd.emit) begin
			found_q <= hit_q ? OUT_DATA_W'(val_q) : '0;
			below_q <= !hit_q;
		end
	end

	assign found_value = found_q;
	assign below_first = below_q;

	a_span_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (span_q < $past(span_q)))
		else $error("search span did not shrink");

	a_base_rises: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (base_q >= $past(base_q)))
		else $error("search base moved down");

	a_hit_base: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (base_q != '0))
		else $error("hit recorded with empty lower part");

endmodule

/* hw/rtl/range_table_value_lookup.sv */
// ----------------------------------------------------------------------------
// range_table_value_lookup
// Predecessor lookup in a sorted table of start keys with attached values.
// ----------------------------------------------------------------------------
// A write item (tuser 0) stores a key and value in a slot and gives no
// result. A lookup item (tuser 1) binary-searches the first entry_count
// slots, capped at the table depth, and returns the value of the greatest
// key not above the query, or 0 with below_first set. A lookup takes the
// item, makes its probes, then loads the result register, and the block
// takes no new item until it is done. An empty search skips the probes.
// If the previous result is still waiting on the output, a finished lookup
// holds in its finish state until that result is taken. The probe rate is
// set by the single table read port and the compare that chooses the next
// probe address. Slots must be written before a search can reach them.
module range_table_value_lookup #(
	parameter int TABLE_DEPTH = 4096,
	parameter int VALUE_BITS  = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration: entry_count
	input  logic                                cfg_we,
	input  logic [rtvl_pkg::CNT_W-1:0]          cfg_wdata,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// slot, entry_key, entry_value, query_key, zero pad
	input  logic [rtvl_pkg::IN_DATA_W-1:0]      s_tdata,
	// mode
	input  logic                                s_tuser,
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// found_value
	output logic [rtvl_pkg::OUT_DATA_W-1:0]     m_tdata,
	// below_first
	output logic                                m_tuser
);
	import rtvl_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rtvl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_mode  (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	rtvl_dp #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.slot       (s_tdata[11:0]),
		.entry_key  (s_tdata[32:12]),
		.entry_value(s_tdata[40:33]),
		.query_key  (s_tdata[61:41]),
		.found_value(m_tdata),
		.below_first(m_tuser)
	);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range table value lookup.
// ----------------------------------------------------------------------------
// Loads range tables through write items and checks every lookup result
// against a local predecessor search that tracks the table as written.
// Tables are small most of the time, one phase plans keys over the whole
// table and loads the slots that searches at the largest counts reach, and a
// few phases use unsorted keys. Both sides of the stream idle in random
// bursts, with one long hold-off on the result side.
// ----------------------------------------------------------------------------
module testbench;
	import rtvl_pkg::*;

	localparam int DEPTH         = 4096;
	localparam int FIELDS_W      = SLOT_W + 2 * KEY_W + EVAL_W;
	localparam int MAX_CYCLES    = 1_200_000;
	localparam int SETTLE_CYCLES = 24;
	localparam int LONG_HOLD     = 400;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	typedef struct {
		logic              mode;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  entry_key;
		logic [EVAL_W-1:0] entry_value;
		logic [KEY_W-1:0]  query_key;
	} table_request_t;

	typedef struct packed {
		logic [EVAL_W-1:0] value;
		logic              below;
	} lookup_result_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CNT_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = MODE_WRITE;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;

	// table as the block should hold it, updated as items are taken
	logic [KEY_W-1:0]  mirror_keys [DEPTH];
	logic [EVAL_W-1:0] mirror_vals [DEPTH];
	int                mirror_count = 1;
	// keys as planned by the stimulus, used to aim queries
	logic [KEY_W-1:0]  planned_keys [DEPTH];
	// slots already queued in the whole-table phase
	bit                slot_loaded [DEPTH];

	table_request_t request_queue [$];
	lookup_result_t expected_lookups [$];

	bit idle_on = 1'b1;
	int holds_asked, holds_served, stall_left, rx_gap, send_gap;
	int error_count, writes_seen, lookups_seen, below_seen, config_writes;
	int random_items, cycle_count;
	table_request_t offered;

	range_table_value_lookup i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predecessor search: halve the span, keep the upper part past a probe
	// whose key is not above the query
	function automatic lookup_result_t find_range_value(logic [KEY_W-1:0] query);
		int n, base, span, half, probe;
		lookup_result_t r;
		n = (mirror_count > DEPTH) ? DEPTH : mirror_count;
		base = 0;
		span = n;
		while (span > 0) begin
			half = span / 2;
			probe = base + half;
			if (query >= mirror_keys[probe]) begin
				base = probe + 1;
				span -= half + 1;
			end else begin
				span = half;
			end
		end
		if (base == 0) begin
			r.value = '0;
			r.below = 1'b1;
		end else begin
			r.value = mirror_vals[base-1];
			r.below = 1'b0;
		end
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_request(table_request_t t);
		return {{(IN_DATA_W-FIELDS_W){1'b0}}, t.query_key, t.entry_value, t.entry_key, t.slot};
	endfunction

	task automatic take_request(table_request_t t);
		if (t.mode == MODE_WRITE) begin
			mirror_keys[t.slot] = t.entry_key;
			mirror_vals[t.slot] = t.entry_value;
			writes_seen++;
		end else begin
			expected_lookups.push_back(find_range_value(t.query_key));
			lookups_seen++;
		end
	endtask

	task automatic check_result(logic [EVAL_W-1:0] value, logic below);
		lookup_result_t want;
		if (expected_lookups.size() == 0) begin
			error_count++;
			if (error_count <= 10)
				$display("unexpected result: found_value %0h below_first %0b", value, below);
		end else begin
			want = expected_lookups.pop_front();
			if (want.below)
				below_seen++;
			if (want.value !== value || want.below !== below) begin
				error_count++;
				if (error_count <= 10)
					$display("mismatch: expected found_value %0h below_first %0b, got %0h %0b",
						want.value, want.below, value, below);
			end
		end
	endtask

	// sender: one item offered at a time, random gaps after acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= MODE_WRITE;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				take_request(offered);
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					offered = request_queue.pop_front();
					s_tdata  <= pack_request(offered);
					s_tuser  <= offered.mode;
					s_tvalid <= 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 19);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks results, stalls in bursts and once for a long stretch
	// that starts with the first result of the held phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			rx_gap = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata, m_tuser);
			if (holds_served != holds_asked && m_tvalid) begin
				holds_served = holds_asked;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					rx_gap = $urandom_range(1, 19);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_lookups.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic queue_write(int slot, logic [KEY_W-1:0] key, logic [EVAL_W-1:0] value);
		table_request_t t;
		t.mode        = MODE_WRITE;
		t.slot        = slot[SLOT_W-1:0];
		t.entry_key   = key;
		t.entry_value = value;
		t.query_key   = KEY_W'($urandom());
		request_queue.push_back(t);
		planned_keys[t.slot] = key;
	endtask

	task automatic queue_lookup(logic [KEY_W-1:0] query);
		table_request_t t;
		t.mode        = MODE_LOOKUP;
		t.slot        = SLOT_W'($urandom());
		t.entry_key   = KEY_W'($urandom());
		t.entry_value = EVAL_W'($urandom());
		t.query_key   = query;
		request_queue.push_back(t);
	endtask

	// queries land on, just under or just over a planned key, at either end of the key range, or anywhere
	function automatic logic [KEY_W-1:0] pick_query(int n);
		logic [KEY_W-1:0] k;
		k = planned_keys[$urandom_range(0, n - 1)];
		case ($urandom_range(0, 6))
			0: return k;
			1: return k - 1'b1;
			2: return k + 1'b1;
			3: return '0;
			4: return KEY_MAX;
			default: return KEY_W'($urandom());
		endcase
	endfunction

	// loads the planned key of every slot that a search over n entries will
	// probe for this query, then queues the lookup itself
	task automatic queue_deep_lookup(int n, logic [KEY_W-1:0] query);
		int base, span, half, probe;
		base = 0;
		span = (n > DEPTH) ? DEPTH : n;
		while (span > 0) begin
			half = span / 2;
			probe = base + half;
			if (!slot_loaded[probe]) begin
				slot_loaded[probe] = 1'b1;
				queue_write(probe, planned_keys[probe], EVAL_W'($urandom()));
			end
			if (query >= planned_keys[probe]) begin
				base = probe + 1;
				span -= half + 1;
			end else begin
				span = half;
			end
		end
		queue_lookup(query);
	endtask

	task automatic wait_idle();
		while (request_queue.size() != 0 || s_tvalid || expected_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror_count = value & ((1 << CNT_W) - 1);
		config_writes++;
	endtask

	task automatic random_table_phase(bit sorted_keys, bit with_hold);
		int n, count, step_max, key, lookups, slot;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(1, 16);
		count = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n) : n;
		write_entry_count(count);
		if (with_hold)
			holds_asked++;
		key = $urandom_range(0, 1000);
		step_max = (int'(KEY_MAX) - 1000) / n;
		for (int i = 0; i < n; i++) begin
			if (sorted_keys)
				key += $urandom_range(0, step_max);
			else
				key = $urandom_range(0, int'(KEY_MAX));
			queue_write(i, key[KEY_W-1:0], EVAL_W'($urandom()));
		end
		// stray writes outside the searched part
		if ($urandom_range(0, 2) == 0)
			queue_write($urandom_range(n, DEPTH - 1), KEY_W'($urandom()), EVAL_W'($urandom()));
		lookups = $urandom_range(6, 24);
		for (int i = 0; i < lookups; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				slot = $urandom_range(0, n - 1);
				queue_write(slot, planned_keys[slot], EVAL_W'($urandom()));
			end else begin
				queue_lookup(pick_query(n));
			end
		end
		random_items += n + lookups;
		wait_idle();
	endtask

	initial begin
		int big_counts [4];
		int phase;
		int deep_count;
		big_counts = '{8191, 4097, 4095, 2048};

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// one entry searched after reset: below, equal, above, extremes
		queue_write(0, 21'h000100, 8'hA5);
		queue_lookup('0);
		queue_lookup(21'h0000FF);
		queue_lookup(21'h000100);
		queue_lookup(KEY_MAX);
		queue_write(DEPTH - 1, KEY_MAX, 8'hFF);
		queue_write(1, KEY_MAX, 8'h5A);
		wait_idle();
		write_entry_count(2);
		queue_lookup(KEY_MAX - 1'b1);
		queue_lookup(KEY_MAX);
		queue_lookup(21'h000100);
		queue_lookup('0);
		wait_idle();
		// empty search
		write_entry_count(0);
		queue_lookup('0);
		queue_lookup(KEY_MAX);
		wait_idle();
		// out of order keys follow the probe sequence
		write_entry_count(3);
		queue_write(2, '0, 8'h00);
		queue_lookup('0);
		queue_lookup(21'h000150);
		queue_lookup(KEY_MAX);
		wait_idle();

		phase = 0;
		while (random_items < 280 || phase < 2) begin
			random_table_phase($urandom_range(0, 4) != 0, phase == 1);
			phase++;
		end

		// sorted keys planned over the whole table, then the largest counts
		// including saturation; only the slots that searches reach are loaded
		for (int i = 0; i < DEPTH; i++) begin
			planned_keys[i] = KEY_W'(i * 500 + $urandom_range(0, 499));
			slot_loaded[i]  = 1'b0;
		end
		write_entry_count(DEPTH);
		for (int i = 0; i < 8; i++)
			queue_deep_lookup(DEPTH, pick_query(DEPTH));
		wait_idle();
		foreach (big_counts[c]) begin
			write_entry_count(big_counts[c]);
			for (int i = 0; i < 3; i++)
				queue_deep_lookup(big_counts[c], pick_query(DEPTH));
			wait_idle();
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		for (int p = 0; p < 3; p++) begin
			deep_count = $urandom_range(1, DEPTH);
			write_entry_count(deep_count);
			for (int i = 0; i < 6; i++)
				queue_deep_lookup(deep_count, pick_query(DEPTH));
			wait_idle();
		end

		$display("covered %0d table writes and %0d lookups (%0d below the first key)",
			writes_seen, lookups_seen, below_seen);
		$display("over %0d entry_count settings from 0 to 8191, sorted and unsorted tables",
			config_writes);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/rtvl_pkg.sv
hw/rtl/rtvl_ram.sv
hw/rtl/rtvl_ctrl.sv
hw/rtl/rtvl_dp.sv
hw/rtl/range_table_value_lookup.sv
bench/testbench.sv
